>>> rtl/b64e_pkg.sv
// shared types, constants and the sextet-to-character mapping for the base64 stream encoder
// no dependencies; used by the front, queue, back and top-level modules

package b64e_pkg;

  // job queue geometry
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  // character constants
  localparam logic [6:0] PadChar = 7'd61;

  // one classified byte: up to four output characters
  typedef struct packed {
    logic [3:0][6:0] chars;  // chars[0] goes out first
    logic [1:0]      cnt;    // number of characters minus one
    logic            last;   // final character carries the message end flag
  } job_t;

  // standard alphabet lookup
  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] ch;
    if (v < 6'd26) begin
      ch = 7'd65 + {1'b0, v};
    end else if (v < 6'd52) begin
      ch = 7'd71 + {1'b0, v};
    end else if (v < 6'd62) begin
      ch = {1'b0, v} - 7'd4;
    end else if (v == 6'd62) begin
      ch = 7'd43;
    end else begin
      ch = 7'd47;
    end
    return ch;
  endfunction

endpackage

>>> rtl/base64_stream_encoder_core.sv
// base64 stream encoder: one byte in, base64 characters out with '=' padding
// an accepted byte's job goes into the queue; its characters then pass through the output register
// one character per cycle unless the output stalls; a byte gives 1 or 2 chars, a last byte up to 4
// bytes are taken every cycle while the two-entry job queue has room; the output port sets the pace
// reset: asynchronous active low, clears group phase, leftover bits, queue and output valid
// depends on b64e_pkg, b64e_front, b64e_queue, b64e_back

module base64_stream_encoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // in_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
  output logic       m_axis_tlast    // out_last
);

  b64e_pkg::job_t push_job;
  b64e_pkg::job_t head_job;
  logic           push;
  logic           pop;
  logic           queue_full;
  logic           queue_empty;
  logic [6:0]     out_char;

  // accept and classify bytes
  b64e_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .queue_full_i (queue_full),
    .in_ready_o   (s_axis_tready),
    .push_o       (push),
    .job_o        (push_job)
  );

  // decoupling queue
  b64e_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .full_o     (queue_full),
    .empty_o    (queue_empty),
    .head_o     (head_job)
  );

  // serialize characters
  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (queue_empty),
    .head_i      (head_job),
    .pop_o       (pop),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_char};

endmodule

>>> rtl/b64e_front.sv
// front end: accepts bytes, tracks group phase and leftover bits, builds character jobs
// depends on b64e_pkg

module b64e_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [7:0]       in_byte_i,
  input  logic             in_last_i,
  input  logic             queue_full_i,
  output logic             in_ready_o,
  output logic             push_o,
  output b64e_pkg::job_t   job_o
);

  localparam logic [1:0] PhaseZero = 2'd0;
  localparam logic [1:0] PhaseOne  = 2'd1;
  localparam logic [1:0] PhaseTwo  = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [3:0] left_q, left_d;
  logic       accept;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign push_o     = accept;

  // classify the byte and form its characters
  always_comb begin
    job_o       = '0;
    job_o.last  = in_last_i;
    phase_d     = PhaseOne;
    left_d      = {2'b00, in_byte_i[1:0]};
    unique case (phase_q)
      PhaseOne: begin
        job_o.chars[0] = b64e_pkg::sextet_char({left_q[1:0], in_byte_i[7:4]});
        job_o.cnt      = 2'd0;
        left_d         = in_byte_i[3:0];
        phase_d        = PhaseTwo;
      end
      PhaseTwo: begin
        job_o.chars[0] = b64e_pkg::sextet_char({left_q, in_byte_i[7:6]});
        job_o.chars[1] = b64e_pkg::sextet_char(in_byte_i[5:0]);
        job_o.cnt      = 2'd1;
        left_d         = 4'd0;
        phase_d        = PhaseZero;
      end
      default: begin
        job_o.chars[0] = b64e_pkg::sextet_char(in_byte_i[7:2]);
        job_o.cnt      = 2'd0;
        left_d         = {2'b00, in_byte_i[1:0]};
        phase_d        = PhaseOne;
      end
    endcase
    // message end: flush leftover bits and pad to four characters
    if (in_last_i) begin
      if (phase_d == PhaseOne) begin
        job_o.chars[1] = b64e_pkg::sextet_char({left_d[1:0], 4'b0000});
        job_o.chars[2] = b64e_pkg::PadChar;
        job_o.chars[3] = b64e_pkg::PadChar;
        job_o.cnt      = 2'd3;
      end else if (phase_d == PhaseTwo) begin
        job_o.chars[1] = b64e_pkg::sextet_char({left_d, 2'b00});
        job_o.chars[2] = b64e_pkg::PadChar;
        job_o.cnt      = 2'd2;
      end
      phase_d = PhaseZero;
      left_d  = 4'd0;
    end
  end

  // group state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseZero;
      left_q  <= 4'd0;
    end else if (accept) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

endmodule

>>> rtl/b64e_queue.sv
// short job queue between the front end and the character serializer
// depends on b64e_pkg

module b64e_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  b64e_pkg::job_t   push_job_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output b64e_pkg::job_t   head_o
);

  b64e_pkg::job_t                  slots_q [b64e_pkg::QueueDepth];
  logic [b64e_pkg::QueueAw-1:0]    wr_ptr_q, rd_ptr_q;
  logic [b64e_pkg::QueueAw:0]      count_q;

  assign full_o  = (count_q == (b64e_pkg::QueueAw+1)'(b64e_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rd_ptr_q];

  // job storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/b64e_back.sv
// back end: walks each queued job into the output reg, one char/cycle while ready
// depends on b64e_pkg

module b64e_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  b64e_pkg::job_t   head_i,
  output logic             pop_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [6:0]       out_char_o,
  output logic             out_last_o
);

  logic [1:0] idx_q;
  logic       valid_q;
  logic [6:0] char_q;
  logic       last_q;
  logic       load;
  logic       final_char;

  assign load       = !empty_i && (!valid_q || out_ready_i);
  assign final_char = (idx_q == head_i.cnt);
  assign pop_o      = load && final_char;

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

  // character index within the head job, and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= final_char ? 2'd0 : idx_q + 2'd1;
      end
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= head_i.chars[idx_q];
      last_q <= head_i.last && final_char;
    end
  end

endmodule

>>> bench/tb_base64_stream_encoder_core.sv
// self-checking testbench for base64_stream_encoder_core: byte stream in, base64 characters out
// depends on rtl/b64e_pkg.sv and rtl/base64_stream_encoder_core.sv

module tb_base64_stream_encoder_core;

  localparam int ItemTarget = 320;  // input items before the stimulus stops
  localparam int PauseAt    = 150;  // sender drains the output once around here
  localparam int DirRows    = 25;

  // one expected output character
  typedef struct packed {
    logic [6:0] ch;
    logic       lst;
  } b64_char_t;

  // directed stimulus row: n_typed of zero means the predictor supplies the characters
  typedef struct packed {
    logic [7:0]  dat;
    logic        lst;
    logic [2:0]  n_typed;
    logic [31:0] txt;  // typed characters, first one in the top byte
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  b64_char_t  exp_chars[$];   // characters still owed by the block, oldest first
  b64_char_t  pred_chars[$];  // characters caused by the latest byte
  logic [3:0] carry_bits = 4'd0;
  logic [1:0] grp_phase = 2'd0;
  string      b64_alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  int mismatches = 0;
  int items_sent = 0;
  int idle_pct = 0;
  int rdy_hold = 0;

  stim_row_t dir_rows [DirRows] = '{
    // one-byte messages, both extremes
    '{8'h00, 1'b1, 3'd4, "AA=="},
    '{8'hFF, 1'b1, 3'd4, "/w=="},
    // full groups of ones and zeros
    '{8'hFF, 1'b0, 3'd1, "/   "},
    '{8'hFF, 1'b0, 3'd1, "/   "},
    '{8'hFF, 1'b1, 3'd2, "//  "},
    '{8'h00, 1'b0, 3'd1, "A   "},
    '{8'h00, 1'b0, 3'd1, "A   "},
    '{8'h00, 1'b1, 3'd2, "AA  "},
    // two-byte message, single pad
    '{8'h4D, 1'b0, 3'd0, 32'd0},
    '{8'h61, 1'b1, 3'd0, 32'd0},
    // three-byte message, no pad
    '{8'h4D, 1'b0, 3'd0, 32'd0},
    '{8'h61, 1'b0, 3'd0, 32'd0},
    '{8'h6E, 1'b1, 3'd0, 32'd0},
    // plus and slash characters, last byte opens a new group
    '{8'hFB, 1'b0, 3'd0, 32'd0},
    '{8'hEF, 1'b0, 3'd0, 32'd0},
    '{8'hBE, 1'b0, 3'd0, 32'd0},
    '{8'h3E, 1'b1, 3'd0, 32'd0},
    '{8'hFC, 1'b0, 3'd0, 32'd0},
    '{8'h00, 1'b1, 3'd0, 32'd0},
    // five-byte message ending in alternating bits, then a one-byte message
    '{8'h80, 1'b0, 3'd0, 32'd0},
    '{8'h01, 1'b0, 3'd0, 32'd0},
    '{8'h7F, 1'b0, 3'd0, 32'd0},
    '{8'hAA, 1'b0, 3'd0, 32'd0},
    '{8'h55, 1'b1, 3'd0, 32'd0},
    '{8'h10, 1'b1, 3'd0, 32'd0}
  };

  base64_stream_encoder_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // alphabet lookup for one sextet
  function automatic logic [6:0] alpha_char(input logic [5:0] v);
    byte c;
    c = b64_alpha[v];
    return c[6:0];
  endfunction

  function automatic void add_char(input logic [6:0] ch, input logic lst);
    b64_char_t e;
    e.ch  = ch;
    e.lst = lst;
    pred_chars.insert(pred_chars.size(), e);
  endfunction

  // characters that one byte completes, plus the tail of a message on its last byte
  function automatic void encode_byte(input logic [7:0] b, input logic lst);
    pred_chars.delete();
    case (grp_phase)
      2'd1: begin
        add_char(alpha_char({carry_bits[1:0], b[7:4]}), 1'b0);
        carry_bits = b[3:0];
        grp_phase  = 2'd2;
      end
      2'd2: begin
        add_char(alpha_char({carry_bits, b[7:6]}), 1'b0);
        add_char(alpha_char(b[5:0]), lst);
        carry_bits = 4'd0;
        grp_phase  = 2'd0;
      end
      default: begin
        add_char(alpha_char(b[7:2]), 1'b0);
        carry_bits = {2'b00, b[1:0]};
        grp_phase  = 2'd1;
      end
    endcase
    if (lst) begin
      if (grp_phase == 2'd1) begin
        add_char(alpha_char({carry_bits[1:0], 4'b0000}), 1'b0);
        add_char(b64e_pkg::PadChar, 1'b0);
        add_char(b64e_pkg::PadChar, 1'b1);
      end else if (grp_phase == 2'd2) begin
        add_char(alpha_char({carry_bits, 2'b00}), 1'b0);
        add_char(b64e_pkg::PadChar, 1'b1);
      end
      carry_bits = 4'd0;
      grp_phase  = 2'd0;
    end
  endfunction

  // random byte biased toward the extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // offer one item, wait for the handshake, then queue what it should produce
  task automatic send_byte(input logic [7:0] b, input logic lst, input logic [2:0] n_typed,
                           input logic [31:0] txt);
    b64_char_t e;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    encode_byte(b, lst);
    if (n_typed == 3'd0) begin
      foreach (pred_chars[k]) exp_chars.insert(exp_chars.size(), pred_chars[k]);
    end else begin
      for (int k = 0; k < n_typed; k++) begin
        e.ch  = txt[30 - 8*k -: 7];
        e.lst = lst && (k == n_typed - 1);
        exp_chars.insert(exp_chars.size(), e);
      end
    end
    items_sent++;
  endtask

  // output check and ready stalls
  always @(posedge clk_i) begin : out_check
    b64_char_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (exp_chars.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected item: char %0d last %0b", m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = exp_chars.pop_front();
        if (m_axis_tdata !== {1'b0, want.ch} || m_axis_tlast !== want.lst) begin
          if (mismatches < 10)
            $display("mismatch: expected char %0d last %0b, got char %0d last %0b",
                     want.ch, want.lst, m_axis_tdata, m_axis_tlast);
          mismatches++;
        end
      end
    end
    if (rdy_hold > 0) begin
      m_axis_tready <= 1'b0;
      rdy_hold      <= rdy_hold - 1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      m_axis_tready <= 1'b0;
      rdy_hold      <= $urandom_range(0, 14);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // main sequence
  initial begin
    int len;
    bit drained;
    drained = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows
    idle_pct = 25;
    foreach (dir_rows[r])
      send_byte(dir_rows[r].dat, dir_rows[r].lst, dir_rows[r].n_typed, dir_rows[r].txt);

    // random messages, idling varied by phase and off at the end
    while (items_sent < ItemTarget) begin
      if (items_sent < 100)      idle_pct = 25;
      else if (items_sent < 180) idle_pct = 0;
      else if (items_sent < 270) idle_pct = 50;
      else                       idle_pct = 0;
      if (!drained && items_sent >= PauseAt) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (exp_chars.size() != 0);
        drained = 1'b1;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
      for (int k = 0; k < len; k++)
        send_byte(pick_byte(), k == len - 1, 3'd0, 32'd0);
    end
    s_axis_tvalid <= 1'b0;

    // drain, then stay quiet a while to catch stray items
    while (exp_chars.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && exp_chars.size() == 0) begin
      $display("base64_stream_encoder_core regression: pass");
    end else begin
      $display("base64_stream_encoder_core regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("base64_stream_encoder_core regression: fail");
    $finish;
  end

endmodule

>>> files.f
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_queue.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder_core.sv
bench/tb_base64_stream_encoder_core.sv
